// ===== sv/drpi_pkg.sv =====
// shared types, constants and the arctangent table for the pose integrator
`timescale 1ns / 1ps

package drpi_pkg;

   localparam int CSR_IDX_W = 4;
   localparam int SCALE_W   = 24;
   localparam int ATAN_IDX_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_VEL_SCALE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_SCALE = CSR_IDX_W'(1);

   localparam logic [SCALE_W-1:0] VEL_SCALE_RST = SCALE_W'(27053);
   localparam logic [SCALE_W-1:0] YAW_SCALE_RST = SCALE_W'(166886);

   // cordic start value, gain 0.60725 in q2.30
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [15:0] QUAT_MAX = 16'sd16384;
   localparam logic signed [15:0] QUAT_MIN = -16'sd16384;

   typedef struct packed {
      logic signed [15:0] pulse;
      logic signed [15:0] yaw_rate;
      logic [15:0]        dt;
   } req_type;

   typedef struct packed {
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic [31:0]        heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] speed;
      logic signed [15:0] yaw_rate_out;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_SPD,
      ST_RND_SPD,
      ST_CORD_HDG,
      ST_MUL_VC,
      ST_RND_VC,
      ST_MUL_VS,
      ST_RND_VS,
      ST_MUL_DX,
      ST_RND_DX,
      ST_MUL_DY,
      ST_RND_DY,
      ST_MUL_RD,
      ST_MUL_DTH,
      ST_RND_DTH,
      ST_HALF_START,
      ST_CORD_HALF,
      ST_EMIT
   } state_type;

   // atan(2^-i) in binary angle units, full turn is 2^32
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/drpi_cordic.sv =====
// iterative cordic rotator giving sine and cosine of a binary angle in q2.30
`timescale 1ns / 1ps

module drpi_cordic import drpi_pkg::*; #(
   parameter int ITERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               busy,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   logic                  busy_ff, busy_in;
   logic [ATAN_IDX_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0]    x_ff, x_in;
   logic signed [31:0]    y_ff, y_in;
   logic signed [31:0]    z_ff, z_in;
   logic                  flip_ff, flip_in;

   logic signed [31:0] x_sh;
   logic signed [31:0] y_sh;
   logic signed [31:0] atan_v;
   logic [31:0]        fold_sum;
   logic               fold;
   logic               last;

   assign x_sh   = x_ff >>> cnt_ff;
   assign y_sh   = y_ff >>> cnt_ff;
   assign atan_v = signed'(atan_entry(cnt_ff));
   assign last   = (cnt_ff == ATAN_IDX_W'(ITERS - 1));

   // fold into [-pi/2, pi/2) by adding pi, negate the result afterwards
   assign fold_sum = angle + 32'h4000_0000;
   assign fold     = fold_sum[31];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = fold ? signed'(angle + 32'h8000_0000) : signed'(angle);
         flip_in = fold;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_v;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign busy  = busy_ff;
   assign cos_q = flip_ff ? -x_ff : x_ff;
   assign sin_q = flip_ff ? -y_ff : y_ff;

endmodule

// ===== sv/dead_reckoning_pose_integrator_core.sv =====
// planar dead-reckoning pose integrator: shared multiplier and cordic under a sequencer
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req_data  (pulse, yaw_rate, dt)
//   rsp      out  rsp_valid / rsp_ready  rsp_data  (pose, quaternion, speed, rate)
//   csr      in   csr_valid / csr_ready  csr_index, csr_data
//
// one request takes two passes of the cordic rotator and the seven products on the
// one multiplier
// reset is synchronous and returns the pose to the origin and the scales to defaults
// req_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next request is taken meanwhile
// csr writes are taken every cycle
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator_core import drpi_pkg::*; #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCALE_W-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [SCALE_W-1:0] vel_scale_ff;
   logic [SCALE_W-1:0] yaw_scale_ff;
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic [31:0]        yaw_ff;
   logic               rsp_valid_ff;

   req_type            req_ff;
   logic signed [65:0] prod_ff;
   logic signed [31:0] speed_ff;
   logic signed [33:0] vc_ff;
   logic signed [33:0] vs_ff;
   rsp_type            rsp_ff;

   // sequencer controls
   logic               cord_start;
   logic [31:0]        cord_angle;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic [4:0]         rnd_sh;

   logic               cord_busy;
   logic signed [31:0] cord_sin;
   logic signed [31:0] cord_cos;

   logic signed [65:0] mul_p;
   logic signed [65:0] rnd_half;
   logic signed [65:0] rnd_sum;
   logic signed [65:0] rnd_out;
   logic signed [36:0] pos_base;
   logic signed [36:0] pos_sum;
   logic signed [31:0] pos_sat;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic               req_fire;
   logic               emit_ok;

   function automatic logic signed [15:0] quat_term(input logic signed [31:0] v);
      logic signed [32:0] s;
      logic signed [32:0] q;
      logic signed [15:0] r;
      s = {v[31], v} + 33'sd32768;
      q = s >>> 16;
      if (q > 33'(QUAT_MAX)) begin
         r = QUAT_MAX;
      end else if (q < 33'(QUAT_MIN)) begin
         r = QUAT_MIN;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

   drpi_cordic #(
      .ITERS (CORDIC_ITERS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .angle (cord_angle),
      .busy  (cord_busy),
      .sin_q (cord_sin),
      .cos_q (cord_cos)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // shared multiplier and rounding shifter
   assign mul_p    = mul_a * mul_b;
   assign rnd_half = 66'sd1 <<< (rnd_sh - 5'd1);
   assign rnd_sum  = prod_ff + rnd_half;
   assign rnd_out  = rnd_sum >>> rnd_sh;

   // position update with saturation, x or y by state
   assign pos_base = (state_ff == ST_RND_DY) ? 37'(pos_y_ff) : 37'(pos_x_ff);
   assign pos_sum  = pos_base + rnd_out[36:0];
   always_comb begin
      if (pos_sum > 37'(POS_MAX)) begin
         pos_sat = POS_MAX;
      end else if (pos_sum < 37'(POS_MIN)) begin
         pos_sat = POS_MIN;
      end else begin
         pos_sat = pos_sum[31:0];
      end
   end

   assign quat_z = quat_term(cord_sin);
   assign quat_w = quat_term(cord_cos);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_fire) state_in = ST_MUL_SPD;
         ST_MUL_SPD:    state_in = ST_RND_SPD;
         ST_RND_SPD:    state_in = ST_CORD_HDG;
         ST_CORD_HDG:   if (!cord_busy) state_in = ST_MUL_VC;
         ST_MUL_VC:     state_in = ST_RND_VC;
         ST_RND_VC:     state_in = ST_MUL_VS;
         ST_MUL_VS:     state_in = ST_RND_VS;
         ST_RND_VS:     state_in = ST_MUL_DX;
         ST_MUL_DX:     state_in = ST_RND_DX;
         ST_RND_DX:     state_in = ST_MUL_DY;
         ST_MUL_DY:     state_in = ST_RND_DY;
         ST_RND_DY:     state_in = ST_MUL_RD;
         ST_MUL_RD:     state_in = ST_MUL_DTH;
         ST_MUL_DTH:    state_in = ST_RND_DTH;
         ST_RND_DTH:    state_in = ST_HALF_START;
         ST_HALF_START: state_in = ST_CORD_HALF;
         ST_CORD_HALF:  if (!cord_busy) state_in = ST_EMIT;
         ST_EMIT:       if (emit_ok) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      cord_start = 1'b0;
      cord_angle = yaw_ff;
      mul_a      = {{18{req_ff.pulse[15]}}, req_ff.pulse};
      mul_b      = {8'd0, vel_scale_ff};
      rnd_sh     = 5'd16;
      unique case (state_ff) inside
         ST_MUL_SPD: begin
            cord_start = 1'b1;
         end
         ST_RND_SPD: begin
            rnd_sh = 5'd8;
         end
         ST_MUL_VC: begin
            mul_a = {{2{speed_ff[31]}}, speed_ff};
            mul_b = cord_cos;
         end
         ST_MUL_VS: begin
            mul_a = {{2{speed_ff[31]}}, speed_ff};
            mul_b = cord_sin;
         end
         ST_RND_VC, ST_RND_VS: begin
            rnd_sh = 5'd30;
         end
         ST_MUL_DX: begin
            mul_a = vc_ff;
            mul_b = {16'd0, req_ff.dt};
         end
         ST_MUL_DY: begin
            mul_a = vs_ff;
            mul_b = {16'd0, req_ff.dt};
         end
         ST_MUL_RD: begin
            mul_a = {{18{req_ff.yaw_rate[15]}}, req_ff.yaw_rate};
            mul_b = {16'd0, req_ff.dt};
         end
         ST_MUL_DTH: begin
            // rate * dt fits 33 bits, held in the product register
            mul_a = prod_ff[33:0];
            mul_b = {8'd0, yaw_scale_ff};
         end
         ST_HALF_START: begin
            cord_start = 1'b1;
            cord_angle = {1'b0, yaw_ff[31:1]};
         end
         default: begin
         end
      endcase
   end

   // control state and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vel_scale_ff <= VEL_SCALE_RST;
         yaw_scale_ff <= YAW_SCALE_RST;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VEL_SCALE: vel_scale_ff <= csr_data;
               CSR_YAW_SCALE: yaw_scale_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_RND_DX) begin
            pos_x_ff <= pos_sat;
         end
         if (state_ff == ST_RND_DY) begin
            pos_y_ff <= pos_sat;
         end
         if (state_ff == ST_RND_DTH) begin
            yaw_ff <= yaw_ff + rnd_out[31:0];
         end
         if (state_ff == ST_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_RND_SPD) begin
         speed_ff <= rnd_out[31:0];
      end
      if (state_ff == ST_RND_VC) begin
         vc_ff <= rnd_out[33:0];
      end
      if (state_ff == ST_RND_VS) begin
         vs_ff <= rnd_out[33:0];
      end
      if (state_ff == ST_EMIT && emit_ok) begin
         rsp_ff.x_pos        <= pos_x_ff;
         rsp_ff.y_pos        <= pos_y_ff;
         rsp_ff.heading      <= yaw_ff;
         rsp_ff.quat_z       <= quat_z;
         rsp_ff.quat_w       <= quat_w;
         rsp_ff.speed        <= speed_ff;
         rsp_ff.yaw_rate_out <= req_ff.yaw_rate;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
